/* rtl/u8s_pkg.sv */
// Shared types and constants for the UTF-8 sanitizer.
package u8s_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_replacement;
        logic       run_last;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_has_out;
        logic cur_avail;
        logic cur_last;
    } t_dp_status;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    localparam logic [20:0] NONCHAR_LO = 21'h00FDD0;
    localparam logic [20:0] NONCHAR_HI = 21'h00FDEF;
    localparam logic [15:0] NONCHAR_END = 16'hFFFE;

endpackage

/* rtl/u8s_ctrl.sv */
// Handshake controller for the UTF-8 sanitizer.
module u8s_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u8s_pkg::t_dp_cmd    o_cmd,
    input  u8s_pkg::t_dp_status i_status
);

    u8s_pkg::t_state r_state;
    u8s_pkg::t_state n_state;
    logic            last_taken;

    assign last_taken = (r_state == u8s_pkg::ST_EMIT) && !i_out_stall && i_status.cur_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            u8s_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.plan_has_out) begin
                    n_state = u8s_pkg::ST_EMIT;
                end
            end
            u8s_pkg::ST_EMIT: begin
                if (last_taken) begin
                    if (i_in_valid && i_status.plan_has_out) begin
                        n_state = u8s_pkg::ST_EMIT;
                    end else begin
                        n_state = u8s_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = u8s_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            u8s_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            u8s_pkg::ST_EMIT: begin
                o_out_valid   = 1'b1;
                o_in_stall    = !last_taken;
                o_cmd.advance = !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.load = i_in_valid && !o_in_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8s_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u8s_pkg::ST_EMIT) |-> i_status.cur_avail)
        else $error("emitting with empty output plan");

    a_idle_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u8s_pkg::ST_IDLE) |-> !i_status.cur_avail)
        else $error("idle with output bytes pending");

    a_load_goes_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_status.plan_has_out) |=> (r_state == u8s_pkg::ST_EMIT))
        else $error("transaction with results did not start emission");

endmodule

/* rtl/u8s_dp.sv */
// Decode datapath: sequence state, output plan and output byte selection.
module u8s_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8s_pkg::t_in_item   i_item,
    input  u8s_pkg::t_dp_cmd    i_cmd,
    output u8s_pkg::t_dp_status o_status,
    output u8s_pkg::t_out_item  o_item
);

    typedef enum logic [1:0] {
        SB_PASS,
        SB_REPL,
        SB_HOLD
    } t_sb_kind;

    logic [7:0]  r_held [3];
    logic [1:0]  r_cnt;
    logic [2:0]  r_len;
    logic [20:0] r_cp;

    logic [7:0]  n_held [3];
    logic [1:0]  n_cnt;
    logic [2:0]  n_len;
    logic [20:0] n_cp;

    logic [2:0]  r_repl_cnt;
    logic [2:0]  r_pass_cnt;
    logic [7:0]  r_pass_buf [4];
    logic [1:0]  r_sub;
    logic [1:0]  r_pidx;

    logic [2:0]  plan_repl;
    logic [2:0]  plan_pass;
    logic [7:0]  plan_buf [4];

    logic [7:0]  b;
    t_sb_kind    sb_kind;
    logic [2:0]  sb_len;
    logic [20:0] sb_cp;
    logic        ascii_bad;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        fits;
    logic [20:0] cp_new;
    logic        complete;
    logic        nonchar;
    logic        repl_phase;
    logic        cur_last;

    assign b = i_item.data_byte;

    always_comb begin
        ascii_bad = (b <= 8'h08) || (b == 8'h0B) || ((b >= 8'h0E) && (b <= 8'h1F))
                    || (b == 8'h7F);
        sb_kind = SB_REPL;
        sb_len  = 3'd0;
        sb_cp   = '0;
        if (b < 8'h80) begin
            sb_kind = ascii_bad ? SB_REPL : SB_PASS;
        end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
            sb_kind = SB_HOLD;
            sb_len  = 3'd2;
            sb_cp   = {16'd0, b[4:0]};
        end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
            sb_kind = SB_HOLD;
            sb_len  = 3'd3;
            sb_cp   = {17'd0, b[3:0]};
        end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
            sb_kind = SB_HOLD;
            sb_len  = 3'd4;
            sb_cp   = {18'd0, b[2:0]};
        end
    end

    always_comb begin
        lo = u8s_pkg::CONT_LO;
        hi = u8s_pkg::CONT_HI;
        if (r_cnt == 2'd1) begin
            case (r_held[0])
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: lo = u8s_pkg::CONT_LO;
            endcase
        end
        fits     = (b >= lo) && (b <= hi);
        cp_new   = {r_cp[14:0], b[5:0]};
        complete = (({1'b0, r_cnt} + 3'd1) >= r_len);
        nonchar  = ((cp_new[15:0] & u8s_pkg::NONCHAR_END) == u8s_pkg::NONCHAR_END)
                   || ((cp_new >= u8s_pkg::NONCHAR_LO) && (cp_new <= u8s_pkg::NONCHAR_HI));
    end

    always_comb begin
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_cp      = r_cp;
        plan_repl = 3'd0;
        plan_pass = 3'd0;
        for (int i = 0; i < 4; i++) begin
            plan_buf[i] = b;
        end
        if (i_item.end_of_stream) begin
            plan_repl = (r_cnt != 2'd0) ? 3'd1 : 3'd0;
            n_cnt = '0;
            n_len = '0;
            n_cp  = '0;
        end else if ((r_cnt != 2'd0) && fits) begin
            if (complete) begin
                if (nonchar) begin
                    plan_repl = 3'd1;
                end else begin
                    plan_pass = {1'b0, r_cnt} + 3'd1;
                    for (int i = 0; i < 3; i++) begin
                        plan_buf[i] = (i < int'(r_cnt)) ? r_held[i] : b;
                    end
                end
                n_cnt = '0;
                n_len = '0;
                n_cp  = '0;
            end else begin
                n_held[r_cnt] = b;
                n_cnt = r_cnt + 2'd1;
                n_cp  = cp_new;
            end
        end else begin
            // empty state, or a bad follow byte: lead and held tail each give one U+FFFD
            plan_repl = {1'b0, r_cnt};
            n_cnt = '0;
            n_len = '0;
            n_cp  = '0;
            case (sb_kind)
                SB_PASS: plan_pass = 3'd1;
                SB_REPL: plan_repl = {1'b0, r_cnt} + 3'd1;
                SB_HOLD: begin
                    n_held[0] = b;
                    n_cnt = 2'd1;
                    n_len = sb_len;
                    n_cp  = sb_cp;
                end
                default: plan_repl = {1'b0, r_cnt} + 3'd1;
            endcase
        end
    end

    assign repl_phase = (r_repl_cnt != 3'd0);

    always_comb begin
        o_item = '0;
        if (repl_phase) begin
            o_item.is_replacement = 1'b1;
            case (r_sub)
                2'd0:    o_item.out_byte = u8s_pkg::REPL_B0;
                2'd1:    o_item.out_byte = u8s_pkg::REPL_B1;
                default: o_item.out_byte = u8s_pkg::REPL_B2;
            endcase
            cur_last = (r_repl_cnt == 3'd1) && (r_sub == 2'd2) && (r_pass_cnt == 3'd0);
        end else begin
            o_item.out_byte = r_pass_buf[r_pidx];
            cur_last = (({1'b0, r_pidx} + 3'd1) == r_pass_cnt);
        end
        o_item.run_last = cur_last;
    end

    assign o_status.plan_has_out = (plan_repl != 3'd0) || (plan_pass != 3'd0);
    assign o_status.cur_avail    = repl_phase || (r_pass_cnt != 3'd0);
    assign o_status.cur_last     = cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_len      <= '0;
            r_cp       <= '0;
            r_repl_cnt <= '0;
            r_pass_cnt <= '0;
            r_sub      <= '0;
            r_pidx     <= '0;
        end else if (i_cmd.load) begin
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_cp       <= n_cp;
            r_repl_cnt <= plan_repl;
            r_pass_cnt <= plan_pass;
            r_sub      <= '0;
            r_pidx     <= '0;
        end else if (i_cmd.advance) begin
            if (repl_phase) begin
                if (r_sub == 2'd2) begin
                    r_sub      <= '0;
                    r_repl_cnt <= r_repl_cnt - 3'd1;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end else if (cur_last) begin
                r_pass_cnt <= '0;
            end else begin
                r_pidx <= r_pidx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_held     <= n_held;
            r_pass_buf <= plan_buf;
        end
    end

    a_held_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> ((r_len >= 3'd2) && (r_len <= 3'd4) && ({1'b0, r_cnt} < r_len)))
        else $error("held count inconsistent with sequence length");

    a_plan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_repl_cnt <= 3'd4) && (r_pass_cnt <= 3'd4))
        else $error("output plan out of range");

    a_pass_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!repl_phase && (r_pass_cnt != 3'd0)) |-> ({1'b0, r_pidx} < r_pass_cnt))
        else $error("pass index beyond pass count");

endmodule

/* rtl/utf8_sanitizer.sv */
// Top level of the streaming UTF-8 sanitizer.
// Takes one raw byte (or an end-of-stream marker) per input transaction and gives back
// sanitized UTF-8, one byte per output transaction, with run_last on the final byte caused
// by each input. An input's results, 0 to 12 bytes, go into the output plan register and
// leave at one byte per cycle while the output is not stalled. The next input is accepted
// in the cycle its predecessor's last byte is taken, or at once when nothing is pending, so
// plain ASCII streams run at one byte per cycle unless the output stalls. An input with no
// result (held lead or continuation byte, empty flush) is absorbed. Replacements are EF BF BD.
module utf8_sanitizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  u8s_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output u8s_pkg::t_out_item o_out_data
);

    u8s_pkg::t_dp_cmd    cmd;
    u8s_pkg::t_dp_status status;

    u8s_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    u8s_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_out_data)
    );

endmodule
